/* hdl/abrc_pkg.sv */
// Shared types, constants and helpers for the alpha blend rectangle compositor.
// No dependencies; every other file imports this package.
package abrc_pkg;

  // Rectangle and address geometry
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned DIM_BITS   = 12;
  localparam int unsigned REG_BITS   = 13;
  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned PROD_BITS  = 26;   // (origin_y + row) * frame_width
  localparam int unsigned SUM_BITS   = 27;   // product + origin_x + column

  // Queue depths
  localparam int unsigned MIDQ_DEPTH = 2;
  localparam int unsigned OUTQ_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RECT_WIDTH   = 3'd0,
    CFG_RECT_HEIGHT  = 3'd1,
    CFG_FRAME_WIDTH  = 3'd2,
    CFG_ORIGIN_X     = 3'd3,
    CFG_ORIGIN_Y     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
  } in_word_t;

  typedef struct packed {
    logic [31:0]          blended_pixel;
    logic [ADDR_BITS-1:0] frame_address;
    logic                 address_overflow;
    logic                 last_pixel;
  } out_word_t;

  typedef struct packed {
    logic [REG_BITS-1:0] rect_width;
    logic [REG_BITS-1:0] rect_height;
    logic [REG_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] origin_x;
    logic [DIM_BITS-1:0] origin_y;
  } cfg_t;

  // One classified word handed from front to back
  typedef struct packed {
    in_word_t            pix;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                last;
  } job_t;

  // Last valid index of a dimension: 0 acts as 1, above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_BITS-1:0] dim_last(input logic [REG_BITS-1:0] v);
    logic [DIM_BITS-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v >= REG_BITS'(MAX_DIM)) begin
      res = DIM_BITS'(MAX_DIM - 1);
    end else begin
      res = v[DIM_BITS-1:0] - DIM_BITS'(1);
    end
    return res;
  endfunction

  // Exact floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

/* hdl/abrc_front.sv */
// Front end: accepts pixel words, tracks column/row position and marks the last pixel.
// Classified words wait in a short queue for the back end. Depends on abrc_pkg.
module abrc_front import abrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word_i,
  output logic     job_valid_o,
  output job_t     job_o,
  input  logic     job_take_i
);

  localparam int unsigned PtrBits = $clog2(MIDQ_DEPTH);
  localparam int unsigned CntBits = $clog2(MIDQ_DEPTH + 1);

  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [DIM_BITS-1:0] w_last, h_last;
  logic                end_col, end_row, accept;

  job_t               queue_q [MIDQ_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               take;

  assign full   = (count_q == CntBits'(MIDQ_DEPTH));
  assign accept = push && !full;
  assign take   = job_take_i && (count_q != '0);

  // Position tracking
  always_comb begin
    w_last  = dim_last(cfg_i.rect_width);
    h_last  = dim_last(cfg_i.rect_height);
    end_col = (col_q >= w_last);
    end_row = (row_q >= h_last);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (end_col) begin
        col_d = '0;
        row_d = end_row ? '0 : row_q + DIM_BITS'(1);
      end else begin
        col_d = col_q + DIM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Queue toward the back end: control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      if (take)   rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      unique case ({accept, take})
        2'b10:   count_q <= count_q + CntBits'(1);
        2'b01:   count_q <= count_q - CntBits'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= '{pix: in_word_i, col: col_q, row: row_q,
                             last: end_col && end_row};
    end
  end

  assign job_valid_o = (count_q != '0);
  assign job_o       = queue_q[rd_ptr_q];

endmodule

/* hdl/abrc_back.sv */
// Back end: blends the color channels and forms the frame address in two steps,
// then holds results in an output queue. Depends on abrc_pkg.
module abrc_back import abrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_take_o,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  localparam int unsigned PtrBits = $clog2(OUTQ_DEPTH);
  localparam int unsigned CntBits = $clog2(OUTQ_DEPTH + 1);

  // Product stage registers
  logic                 s1_valid_q;
  logic [15:0]          s1_sa_q [3];
  logic [15:0]          s1_da_q [3];
  logic [7:0]           s1_alpha_q;
  logic [PROD_BITS-1:0] s1_prod_q;
  logic [DIM_BITS:0]    s1_offs_q;
  logic                 s1_last_q;

  logic [7:0]           alpha, inv_alpha;
  logic [DIM_BITS:0]    row_abs;
  logic [15:0]          mix [3];
  logic [SUM_BITS-1:0]  addr_full;
  out_word_t            result;

  out_word_t          queue_q [OUTQ_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic [CntBits:0]   committed;
  logic               push_res, pop_res;

  // Issue only when the result queue has room for everything in flight
  assign committed  = {1'b0, count_q} + {{CntBits{1'b0}}, s1_valid_q};
  assign job_take_o = job_valid_i && (committed < (CntBits + 1)'(OUTQ_DEPTH));

  assign alpha     = job_i.pix.src_pixel[31:24];
  assign inv_alpha = 8'd255 - alpha;
  assign row_abs   = {1'b0, cfg_i.origin_y} + {1'b0, job_i.row};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= job_take_o;
    end
  end

  // Channel and address products
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      for (int c = 0; c < 3; c++) begin
        s1_sa_q[c] <= 16'(job_i.pix.src_pixel[8*c +: 8]) * 16'(alpha);
        s1_da_q[c] <= 16'(job_i.pix.dst_pixel[8*c +: 8]) * 16'(inv_alpha);
      end
      s1_alpha_q <= alpha;
      s1_prod_q  <= PROD_BITS'(row_abs) * PROD_BITS'(cfg_i.frame_width);
      s1_offs_q  <= {1'b0, cfg_i.origin_x} + {1'b0, job_i.col};
      s1_last_q  <= job_i.last;
    end
  end

  // Sum, divide by 255, final address add
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix[c] = s1_sa_q[c] + s1_da_q[c];
    end
    addr_full = {1'b0, s1_prod_q} + {{(SUM_BITS - DIM_BITS - 1){1'b0}}, s1_offs_q};
    result.blended_pixel    = {s1_alpha_q, div255(mix[2]), div255(mix[1]),
                               div255(mix[0])};
    result.frame_address    = addr_full[ADDR_BITS-1:0];
    result.address_overflow = |addr_full[SUM_BITS-1:ADDR_BITS];
    result.last_pixel       = s1_last_q;
  end

  // Result queue control
  assign push_res = s1_valid_q;
  assign empty    = (count_q == '0);
  assign pop_res  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_res) wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      if (pop_res)  rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      unique case ({push_res, pop_res})
        2'b10:   count_q <= count_q + CntBits'(1);
        2'b01:   count_q <= count_q - CntBits'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_res) queue_q[wr_ptr_q] <= result;
  end

  assign out_word_o = queue_q[rd_ptr_q];

endmodule

/* hdl/alpha_blend_rect_compositor.sv */
// Top level of the alpha blend rectangle compositor: configuration registers,
// front end and back end. Depends on abrc_pkg, abrc_front and abrc_back.
//
// Source-over blending of a source rectangle onto a frame, one word per clock.
// Push source and destination pixels in raster order; each word gives one result
// with the blended pixel (source alpha kept), the frame address wrapped to 24 bits
// with an overflow flag, and a flag on the rectangle's last pixel. Sustained rate
// is one word per cycle while results are popped; a taken word passes through the
// two-entry classify queue and the multiply stage, whose sums are written straight
// into the four-entry result queue. Write registers only while idle.
module alpha_blend_rect_compositor import abrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [REG_BITS-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  in_word_t            in_word_i,
  output logic                empty,
  input  logic                pop,
  output out_word_t           out_word_o
);

  cfg_t cfg_q;
  logic job_valid, job_take;
  job_t job;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect_width    <= REG_BITS'(1);
      cfg_q.rect_height   <= REG_BITS'(1);
      cfg_q.frame_width   <= REG_BITS'(1);
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_data_i;
        CFG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_data_i;
        CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data_i;
        CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data_i[DIM_BITS-1:0];
        CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data_i[DIM_BITS-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  abrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  abrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule
